// ===== rtl/base64_stream_decoder_macros.svh =====
// Assertion helpers shared by the decoder modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64d check failed");

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

// ===== rtl/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    // Width of the running byte counter; shown on the port as its low 24 bits.
    localparam int COUNT_BITS = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Run modes.
    localparam logic [1:0] MODE_DECODE  = 2'd0;
    localparam logic [1:0] MODE_IGNORE  = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // One queued job: 1 to 3 results to emit.
    typedef struct packed {
        logic [1:0]            kind;
        logic [1:0]            num;
        logic [2:0][7:0]       bytes;
        logic [COUNT_BITS-1:0] base;
    } t_job;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.ok  = 1'b1;
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.ok  = 1'b1;
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == PLUS_CHAR) begin
            r.ok  = 1'b1;
            r.val = 6'd62;
        end else if (c == SLASH_CHAR) begin
            r.ok  = 1'b1;
            r.val = 6'd63;
        end else if (c == PAD_CHAR) begin
            r.ok  = 1'b1;
            r.val = 6'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_front.sv =====
`default_nettype none

module b64d_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire  [7:0]             i_char_code,
    input  wire                    i_is_terminator,
    output logic                   o_ready,
    input  wire                    i_q_full,
    output logic                   o_push,
    output b64d_pkg::t_job         o_job
);
    import b64d_pkg::*;
    `include "base64_stream_decoder_macros.svh"

    logic [1:0]            r_gp, n_gp;
    logic [17:0]           r_store, n_store;
    logic                  r_pad, n_pad;
    logic [1:0]            r_mode, n_mode;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  accept;
    logic                  is_pad;
    t_sextet               sx;
    logic [COUNT_BITS:0]   sum;
    logic [1:0]            num;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign sx      = sextet_of(i_char_code);
    assign is_pad  = (i_char_code == PAD_CHAR);
    assign num     = r_pad ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
    assign sum     = {1'b0, r_count} + (COUNT_BITS+1)'(num);

    always_comb begin
        n_gp    = r_gp;
        n_store = r_store;
        n_pad   = r_pad;
        n_mode  = r_mode;
        n_count = r_count;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.base = r_count;
        o_job.num  = 2'd1;
        if (accept) begin
            priority if (i_is_terminator) begin
                if (r_mode == MODE_DECODE) begin
                    o_push     = 1'b1;
                    o_job.kind = (r_gp != 2'd0) ? KIND_ERROR : KIND_DONE;
                end else if (r_mode == MODE_IGNORE) begin
                    o_push     = 1'b1;
                    o_job.kind = KIND_DONE;
                end
                n_gp    = 2'd0;
                n_store = '0;
                n_pad   = 1'b0;
                n_mode  = MODE_DECODE;
                n_count = '0;
            end else if (r_mode == MODE_DECODE) begin
                priority if (!sx.ok) begin
                    o_push     = 1'b1;
                    o_job.kind = KIND_ERROR;
                    n_mode     = MODE_DISCARD;
                end else if (r_gp != 2'd3) begin
                    n_store = {r_store[11:0], sx.val};
                    if (r_gp == 2'd2) begin
                        n_pad = is_pad;
                    end
                    n_gp = r_gp + 2'd1;
                end else begin
                    o_push         = 1'b1;
                    o_job.kind     = KIND_DATA;
                    o_job.num      = num;
                    o_job.bytes[0] = {r_store[17:12], r_store[11:10]};
                    o_job.bytes[1] = {r_store[9:6], r_store[5:2]};
                    o_job.bytes[2] = {r_store[1:0], sx.val};
                    n_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
                    n_gp    = 2'd0;
                    n_store = '0;
                    n_pad   = 1'b0;
                    if (num != 2'd3) begin
                        n_mode = MODE_IGNORE;
                    end
                end
            end else begin
                // ignoring or discarding: the character is dropped
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= 2'd0;
            r_store <= '0;
            r_pad   <= 1'b0;
            r_mode  <= MODE_DECODE;
            r_count <= '0;
        end else begin
            r_gp    <= n_gp;
            r_store <= n_store;
            r_pad   <= n_pad;
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // After a padded group the group state is always cleared.
    `B64D_ASSERT_NOW(a_ignore_clean, r_mode == MODE_IGNORE, r_gp == 2'd0 && !r_pad)
    // Pad flag only set once the third character is in.
    `B64D_ASSERT_NOW(a_pad_pos, r_pad, r_gp == 2'd3)
    // A terminator always returns the decoder to its idle state.
    `B64D_ASSERT_NEXT(a_term_reset, accept && i_is_terminator,
        r_gp == 2'd0 && r_mode == MODE_DECODE && r_count == '0)

endmodule

`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none

module b64d_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  b64d_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output b64d_pkg::t_job  o_head
);
    import b64d_pkg::*;
    `include "base64_stream_decoder_macros.svh"

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    `B64D_ASSERT_NOW(a_no_overflow, i_push, !o_full)
    `B64D_ASSERT_NOW(a_no_underflow, i_pop, !o_empty)
    `B64D_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== rtl/b64d_back.sv =====
`default_nettype none

module b64d_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_empty,
    input  b64d_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [1:0]      o_result_kind,
    output logic [7:0]      o_data_byte,
    output logic [23:0]     o_byte_count,
    output logic            o_last_of_run
);
    import b64d_pkg::*;
    `include "base64_stream_decoder_macros.svh"

    logic [1:0]                r_idx, n_idx;
    logic                      r_valid;
    logic [1:0]                r_kind;
    logic [7:0]                r_byte;
    logic [OUT_COUNT_BITS-1:0] r_count;
    logic                      r_last;

    logic                  load;
    logic                  last;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] cnt;

    assign load  = !i_q_empty && (!r_valid || i_ready);
    assign last  = ((r_idx + 2'd1) == i_job.num);
    assign o_pop = load && last;
    assign n_idx = load ? (last ? 2'd0 : r_idx + 2'd1) : r_idx;

    // Count after this byte, saturating.
    assign sum = {1'b0, i_job.base} + (COUNT_BITS+1)'(r_idx) + (COUNT_BITS+1)'(1);
    always_comb begin
        cnt = i_job.base;
        if (i_job.kind == KIND_DATA) begin
            cnt = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_job.kind;
            r_byte  <= (i_job.kind == KIND_DATA) ? i_job.bytes[r_idx] : 8'd0;
            r_count <= OUT_COUNT_BITS'(cnt);
            r_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_data_byte   = r_byte;
    assign o_byte_count  = r_count;
    assign o_last_of_run = r_last;

    `B64D_ASSERT_NOW(a_idx_in_job, !i_q_empty, r_idx < i_job.num)
    `B64D_ASSERT_NOW(a_single_status, !i_q_empty && i_job.kind != KIND_DATA, i_job.num == 2'd1)
    `B64D_ASSERT_NOW(a_idle_idx, i_q_empty, r_idx == 2'd0)

endmodule

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// base64_stream_decoder: streaming base64 decoder, one character a word.
//
// Input channel (i_valid / o_ready): i_char_code carries one encoded character,
// or i_is_terminator marks the end of a string. Output channel (o_valid /
// i_ready): one result word per handshake, kind data byte, done or error,
// with the running byte count; o_last_of_run flags the final result of an
// input word. A fourth character yields up to three data words.
//
// Throughput: one input word per clock while the queue is not full, one
// result word per clock while the receiver is ready. The front end
// classifies each word in the cycle it is accepted and queues a job; the back
// end plays a job out at one result a cycle from the queue head while the
// receiver is ready. A job enters the queue at the accepting edge, and the
// output register loads its first result once free or being taken.
//
// Reset (synchronous, active low) clears the group, mode and count state, the
// queue and the output valid flag. When the receiver stalls the output
// register holds; the four-entry queue absorbs further jobs and o_ready
// drops only when the queue is full.
`default_nettype none

module base64_stream_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_char_code,
    input  wire         i_is_terminator,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [23:0] o_byte_count,
    output logic        o_last_of_run
);
    import b64d_pkg::*;

    // front -> queue
    logic q_push;
    t_job q_in;
    logic q_full;
    // queue -> back
    logic q_pop;
    logic q_empty;
    t_job q_head;

    // Front: group assembly, alphabet check, pad and mode tracking, counter.
    b64d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_char_code     (i_char_code),
        .i_is_terminator (i_is_terminator),
        .o_ready         (o_ready),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (q_in)
    );

    // Job queue lets the front keep taking words while results drain.
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: sequences each job into result words via the output register.
    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_data_byte   (o_data_byte),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== sim/tb_base64_stream_decoder.sv =====
`timescale 1ns / 1ps

import b64d_pkg::*;

// One result word as seen on the output channel.
typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [23:0] count;
    logic        last;
} t_result;

// One input word: a character, or a terminator.
typedef struct packed {
    logic [7:0] code;
    logic       term;
} t_word;

// Tracks the decoder's string state and holds the result words still owed.
class decoded_result_board;
    t_result     pending_results[$];
    int unsigned mismatches;

    logic [1:0]  group_pos;
    logic [17:0] sextets;      // first three sextets of the group, oldest on top
    logic        pad_third;
    logic [1:0]  mode;
    logic [23:0] byte_total;

    function new();
        mismatches = 0;
        clear_string();
    endfunction

    function void clear_string();
        group_pos  = '0;
        sextets    = '0;
        pad_third  = 1'b0;
        mode       = MODE_DECODE;
        byte_total = '0;
    endfunction

    // Alphabet lookup; pad counts as sextet zero.
    static function bit sextet_value(input logic [7:0] c, output logic [5:0] v);
        v = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd26);
            return 1'b1;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
            return 1'b1;
        end
        if (c == PLUS_CHAR) begin
            v = 6'd62;
            return 1'b1;
        end
        if (c == SLASH_CHAR) begin
            v = 6'd63;
            return 1'b1;
        end
        return (c == PAD_CHAR);
    endfunction

    function void push_result(input logic [1:0] kind, input logic [7:0] data);
        t_result r;
        r.kind  = kind;
        r.data  = data;
        r.count = byte_total;
        r.last  = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Notes an accepted word; returns 0 when the block merely drops it.
    function bit take_word(input logic [7:0] c, input logic term);
        logic [5:0] s;
        logic [7:0] b [3];
        int         n_out;
        int         k;
        int         size_in;
        bit         live;
        size_in = pending_results.size();
        live    = term || (mode == MODE_DECODE);
        if (term) begin
            if (mode == MODE_DECODE)
                push_result(group_pos != 2'd0 ? KIND_ERROR : KIND_DONE, 8'h00);
            else if (mode == MODE_IGNORE)
                push_result(KIND_DONE, 8'h00);
            clear_string();
        end else if (mode == MODE_DECODE) begin
            if (!sextet_value(c, s)) begin
                push_result(KIND_ERROR, 8'h00);
                mode = MODE_DISCARD;
            end else if (group_pos != 2'd3) begin
                sextets = {sextets[11:0], s};
                if (group_pos == 2'd2)
                    pad_third = (c == PAD_CHAR);
                group_pos++;
            end else begin
                b[0]  = {sextets[17:12], sextets[11:10]};
                b[1]  = {sextets[9:6], sextets[5:2]};
                b[2]  = {sextets[1:0], s};
                n_out = pad_third ? 1 : ((c == PAD_CHAR) ? 2 : 3);
                for (k = 0; k < n_out; k++) begin
                    if (byte_total != COUNT_MAX)
                        byte_total++;
                    push_result(KIND_DATA, b[k]);
                end
                group_pos = '0;
                sextets   = '0;
                pad_third = 1'b0;
                if (n_out < 3)
                    mode = MODE_IGNORE;
            end
        end
        if (pending_results.size() > size_in)
            pending_results[pending_results.size() - 1].last = 1'b1;
        return live;
    endfunction

    function void report(input t_result got, input t_result want, input bit had_want);
        mismatches++;
        if (mismatches <= 10) begin
            if (had_want)
                $display("%0t: result mismatch, exp kind %0d byte %02h count %0d last %0b, %s",
                         $time, want.kind, want.data, want.count, want.last,
                         $sformatf("got kind %0d byte %02h count %0d last %0b",
                                   got.kind, got.data, got.count, got.last));
            else
                $display("%0t: unexpected result, got kind %0d byte %02h count %0d last %0b",
                         $time, got.kind, got.data, got.count, got.last);
        end
    endfunction

    function void check_result(input t_result got);
        t_result want;
        want = '0;
        if (pending_results.size() == 0) begin
            report(got, want, 1'b0);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.count !== want.count || got.last !== want.last)
            report(got, want, 1'b1);
    endfunction
endclass

module tb_base64_stream_decoder;

    localparam int ITEM_TARGET  = 310;   // minimum input words over the whole run
    localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 16;    // settle time once nothing is owed

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_char_code     = 8'h00;
    logic        i_is_terminator = 1'b0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_data_byte;
    logic [23:0] o_byte_count;
    logic        o_last_of_run;

    decoded_result_board board = new();

    // Sender side bookkeeping
    t_word plan[$];
    int    burst_left  = 0;
    int    steady_left = 0;   // words still to send back to back, no gaps
    int    sent_words  = 0;

    // Receiver side: the stimulus bumps hold_req, the receiver acks it and
    // counts the hold-off itself.
    int         hold_req    = 0;
    int         hold_ack    = 0;
    int         hold_left   = 0;
    logic [5:0] pattern_cnt = '0;
    logic [1:0] pattern_sel = '0;

    int stall_cycles = 0;

    base64_stream_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_is_terminator (i_is_terminator),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_kind   (o_result_kind),
        .o_data_byte     (o_data_byte),
        .o_byte_count    (o_byte_count),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Word planning
    // ---------------------------------------------------------------
    function automatic logic [7:0] rand_alpha();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26)
            return 8'(8'h41 + idx);
        if (idx < 52)
            return 8'(8'h61 + idx - 26);
        if (idx < 62)
            return 8'(8'h30 + idx - 52);
        return (idx == 62) ? PLUS_CHAR : SLASH_CHAR;
    endfunction

    function automatic logic [7:0] rand_invalid();
        logic [7:0] c;
        t_sextet    sx;
        do begin
            c  = 8'($urandom_range(0, 255));
            sx = sextet_of(c);
        end while (sx.ok);
        return c;
    endfunction

    function automatic void plan_word(input logic [7:0] c, input logic term);
        t_word w;
        w.code = c;
        w.term = term;
        plan.push_back(w);
    endfunction

    function automatic void plan_text(input string s);
        for (int k = 0; k < s.len(); k++)
            plan_word(s[k], 1'b0);
    endfunction

    // Terminator; the char code rides along with random content.
    function automatic void plan_end();
        plan_word(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // Mostly well formed strings with random content, the rest broken or noise.
    function automatic void plan_random_string();
        int shape;
        int groups;
        int pads;
        shape  = $urandom_range(0, 9);
        groups = $urandom_range(0, 4);
        case (shape)
            0, 1, 2, 3, 4, 5: begin
                repeat (groups * 4) plan_word(rand_alpha(), 1'b0);
                pads = $urandom_range(0, 2);
                if (pads != 0) begin
                    plan_word(rand_alpha(), 1'b0);
                    plan_word(rand_alpha(), 1'b0);
                    if (pads == 2) begin
                        plan_word(PAD_CHAR, 1'b0);
                        // now and then a real char in fourth place after the pad in third
                        plan_word(($urandom_range(0, 3) == 0) ? rand_alpha() : PAD_CHAR,
                                  1'b0);
                    end else begin
                        plan_word(rand_alpha(), 1'b0);
                        plan_word(PAD_CHAR, 1'b0);
                    end
                    // trailing junk, dropped while ignoring
                    repeat ($urandom_range(0, 3)) plan_word(8'($urandom_range(0, 255)), 1'b0);
                end
                plan_end();
            end
            6: begin
                // terminator part way through a group
                repeat (groups * 4 + $urandom_range(1, 3)) plan_word(rand_alpha(), 1'b0);
                plan_end();
            end
            7: begin
                repeat ($urandom_range(0, 9)) plan_word(rand_alpha(), 1'b0);
                plan_word(rand_invalid(), 1'b0);
                repeat ($urandom_range(0, 4)) plan_word(8'($urandom_range(0, 255)), 1'b0);
                plan_end();
            end
            8: begin
                repeat ($urandom_range(1, 8))
                    plan_word(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
            end
            default: begin
                // pads sprinkled anywhere
                repeat ($urandom_range(1, 12))
                    plan_word(($urandom_range(0, 2) == 0) ? PAD_CHAR : rand_alpha(), 1'b0);
                plan_end();
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ---------------------------------------------------------------
    task automatic send_word(input t_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (steady_left == 0) begin
                gap = $urandom_range(1, 5);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_char_code     <= w.code;
        i_is_terminator <= w.term;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        void'(board.take_word(w.code, w.term));
        sent_words++;
        burst_left--;
        if (steady_left != 0)
            steady_left--;
    endtask

    task automatic send_plan();
        t_word w;
        while (plan.size() != 0) begin
            w = plan.pop_front();
            send_word(w);
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Alphabet edges: A Z a z 0 9 + / over two full groups
        plan_text("AZaz09+/");
        plan_end();
        // Pad in third place, real char in fourth: a single byte
        plan_text("Zg=A");
        plan_end();
        // Pad in first place, pad in fourth: two bytes, then a char that is ignored
        plan_text("=m8=x");
        plan_end();
        // Code zero is invalid, all-ones is discarded, terminator gives nothing
        plan_word(8'h00, 1'b0);
        plan_word(8'hFF, 1'b0);
        plan_end();
        // Terminator mid-group, then an empty string
        plan_text("Q");
        plan_end();
        plan_end();
        send_plan();

        // Long receiver hold-off while the sender keeps offering back to back
        hold_req    <= hold_req + 1;
        steady_left  = 40;

        while (sent_words < ITEM_TARGET) begin
            plan_random_string();
            send_plan();
        end
        i_valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: own stall pattern, switched when its pattern counter wraps,
    // plus the one long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            case (pattern_sel)
                2'd0:    i_ready <= 1'b1;
                2'd1:    i_ready <= 1'($urandom_range(0, 1));
                2'd2:    i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= (pattern_cnt[1:0] != 2'd0);
            endcase
            pattern_cnt <= pattern_cnt + 6'd1;
            if (pattern_cnt == 6'h3F)
                pattern_sel <= 2'($urandom_range(0, 3));
        end
    end

    // Output monitor: values sampled are those before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(t_result'{o_result_kind, o_data_byte, o_byte_count,
                                         o_last_of_run});
    end

    // Watchdog: too long without a word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
